/* rtl/windowed_time_to_collision_defines.svh */
// ----------------------------------------------------------------------------
// Windowed time-to-collision defines
// Assertion macros shared by the RTL of the TTC estimator.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_TIME_TO_COLLISION_DEFINES_SVH
`define WINDOWED_TIME_TO_COLLISION_DEFINES_SVH

// same-cycle implication
`define WTTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("windowed_time_to_collision: same-cycle check failed");

// next-cycle implication
`define WTTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("windowed_time_to_collision: next-cycle check failed");

`endif

/* rtl/wttc_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed time-to-collision package
// Field widths, codes, reset values and shared types of the TTC estimator.
// ----------------------------------------------------------------------------
package wttc_pkg;

	localparam int WINDOW_DEPTH_DEF = 16;

	localparam int CMD_W      = 2;
	localparam int DIST_W     = 16;
	localparam int TIME_W     = 32;
	localparam int SPEED_W    = 16;
	localparam int TTC_W      = 16;
	localparam int STATUS_W   = 3;
	localparam int CFG_LEN_W  = 5;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LANE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EGO    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TTC_LIMIT     = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NOT_IN_LANE  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSUFFICIENT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID_TIME = 3'd2;
	localparam logic [STATUS_W-1:0] ST_STATIONARY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_APPROACHING  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MOVING_AWAY  = 3'd5;

	localparam logic [TTC_W-1:0] TTC_INFINITE = 16'hFFFF;

	localparam logic [CFG_LEN_W-1:0]  RST_WINDOW_LENGTH = 5'd10;
	localparam logic [CFG_DATA_W-1:0] RST_MIN_SPEED     = 16'd300;
	localparam logic [CFG_DATA_W-1:0] RST_TTC_LIMIT     = 16'd2000;

	localparam int MIN_SAMPLES   = 3;
	localparam int SPEED_SCALE   = 1000000;	// us -> s
	localparam int SPEED_SCALE_W = 20;
	localparam int TTC_SCALE     = 1000;	// s -> ms
	localparam int TTC_SCALE_W   = 10;

	localparam int DIV_NUM_W = DIST_W + SPEED_SCALE_W;
	localparam int DIV_DEN_W = DIV_NUM_W + 1;
	localparam int REL_W     = DIV_NUM_W + 2;
	localparam int TTC_NUM_W = DIST_W + TTC_SCALE_W;

	typedef struct packed {
		logic wr;
		logic rd;
	} win_req_t;

endpackage

/* rtl/wttc_if.sv */
// ----------------------------------------------------------------------------
// Windowed time-to-collision channels
// Valid/ready channels for events in and TTC results out.
// ----------------------------------------------------------------------------
interface wttc_evt_if;
	logic                              valid;
	logic                              ready;
	logic [wttc_pkg::CMD_W-1:0]        command;
	logic [wttc_pkg::DIST_W-1:0]       distance_mm;
	logic [wttc_pkg::TIME_W-1:0]       timestamp_us;
	logic                              in_lane;
	logic signed [wttc_pkg::SPEED_W-1:0] ego_speed_mm_s;

	modport source (output valid, command, distance_mm, timestamp_us, in_lane,
		ego_speed_mm_s, input ready);
	modport sink (input valid, command, distance_mm, timestamp_us, in_lane,
		ego_speed_mm_s, output ready);
endinterface

interface wttc_res_if;
	logic                          valid;
	logic                          ready;
	logic [wttc_pkg::TTC_W-1:0]    ttc_ms;
	logic [wttc_pkg::STATUS_W-1:0] motion_status;
	logic                          low_ttc;

	modport source (output valid, ttc_ms, motion_status, low_ttc, input ready);
	modport sink (input valid, ttc_ms, motion_status, low_ttc, output ready);
endinterface

/* rtl/wttc_window.sv */
// ----------------------------------------------------------------------------
// Windowed time-to-collision sample window
// Circular store of distance/time samples with fill count, one write and two
// registered reads (newest and oldest entry) per cycle.
// ----------------------------------------------------------------------------
module wttc_window #(
	parameter int WINDOW_DEPTH = wttc_pkg::WINDOW_DEPTH_DEF,
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wttc_pkg::win_req_t              req,
	input  logic [wttc_pkg::DIST_W-1:0]     wr_dist,
	input  logic [wttc_pkg::TIME_W-1:0]     wr_time,
	input  logic [wttc_pkg::CFG_LEN_W-1:0]  win_len,
	output logic [CNT_W-1:0]                count,
	output logic [wttc_pkg::DIST_W-1:0]     new_dist,
	output logic [wttc_pkg::TIME_W-1:0]     new_time,
	output logic [wttc_pkg::DIST_W-1:0]     old_dist,
	output logic [wttc_pkg::TIME_W-1:0]     old_time
);

	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam int AW    = CNT_W + 1;
	localparam int LW    = (CNT_W > wttc_pkg::CFG_LEN_W) ? CNT_W : wttc_pkg::CFG_LEN_W;
	localparam int ENT_W = wttc_pkg::DIST_W + wttc_pkg::TIME_W;

	logic [ENT_W-1:0] mem [WINDOW_DEPTH];
	logic [ENT_W-1:0] rd_new_q;
	logic [ENT_W-1:0] rd_old_q;

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	logic [LW-1:0]    eff_len;
	logic [AW-1:0]    len_a;
	logic [AW-1:0]    cnt_inc;
	logic [CNT_W-1:0] count_nxt;
	logic [IDX_W-1:0] head_nxt;
	logic [IDX_W-1:0] newest;
	logic [AW-1:0]    head_a;
	logic [AW-1:0]    cnt_a;
	logic [AW-1:0]    old_a;
	logic [IDX_W-1:0] oldest;

	// zero acts as one, anything past the depth acts as the depth
	always_comb begin
		if (win_len == '0) begin
			eff_len = LW'(1);
		end else if (LW'(win_len) > LW'(WINDOW_DEPTH)) begin
			eff_len = LW'(WINDOW_DEPTH);
		end else begin
			eff_len = LW'(win_len);
		end
	end

	assign len_a     = AW'(eff_len);
	assign cnt_inc   = AW'(count_q) + AW'(1);
	assign count_nxt = (cnt_inc > len_a) ? CNT_W'(len_a) : CNT_W'(cnt_inc);
	assign head_nxt  = (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign newest    = (head_q == '0) ? IDX_W'(WINDOW_DEPTH - 1) : head_q - IDX_W'(1);

	assign head_a = AW'(head_q);
	assign cnt_a  = AW'(count_q);
	assign old_a  = (head_a >= cnt_a) ? head_a - cnt_a : head_a + AW'(WINDOW_DEPTH) - cnt_a;
	assign oldest = old_a[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (req.wr) begin
			head_q  <= head_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[head_q] <= {wr_dist, wr_time};
		end
		if (req.rd) begin
			rd_new_q <= mem[newest];
			rd_old_q <= mem[oldest];
		end
	end

	assign count    = count_q;
	assign new_dist = rd_new_q[ENT_W-1:wttc_pkg::TIME_W];
	assign new_time = rd_new_q[wttc_pkg::TIME_W-1:0];
	assign old_dist = rd_old_q[ENT_W-1:wttc_pkg::TIME_W];
	assign old_time = rd_old_q[wttc_pkg::TIME_W-1:0];

endmodule

/* rtl/wttc_div.sv */
// ----------------------------------------------------------------------------
// Windowed time-to-collision serial divider
// Restoring divider, one quotient bit per cycle, shared by the speed and the
// TTC division.
// ----------------------------------------------------------------------------
module wttc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [wttc_pkg::DIV_NUM_W-1:0]   num,
	input  logic [wttc_pkg::DIV_DEN_W-1:0]   den,
	output logic                             done,
	output logic [wttc_pkg::DIV_NUM_W-1:0]   quot
);

	localparam int NUM_W = wttc_pkg::DIV_NUM_W;
	localparam int DEN_W = wttc_pkg::DIV_DEN_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// remainder stays below the divisor, so the borrow is the compare
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = !diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

/* rtl/windowed_time_to_collision.sv */
// ----------------------------------------------------------------------------
// Windowed time to collision: windowed speed estimate and TTC classification
// A result is produced off lane, with too few samples, for a zero span, after the
// speed division (stationary or moving away) or after a TTC division (approaching).
// One transaction in flight; the next is taken the cycle after the result is
// registered, later while a result is held. Async reset.
// ----------------------------------------------------------------------------
`include "windowed_time_to_collision_defines.svh"

module windowed_time_to_collision #(
	parameter int WINDOW_DEPTH = wttc_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	wttc_evt_if.sink                          events,
	wttc_res_if.source                        results,
	input  logic                              cfg_we,
	input  logic [wttc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wttc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int NUM_W  = wttc_pkg::DIV_NUM_W;
	localparam int DEN_W  = wttc_pkg::DIV_DEN_W;
	localparam int REL_W  = wttc_pkg::REL_W;
	localparam int TTC_W  = wttc_pkg::TTC_W;
	localparam int DIST_W = wttc_pkg::DIST_W;
	localparam int TIME_W = wttc_pkg::TIME_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_READ = 4'd1;
	localparam logic [3:0] S_SPAN = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_DIV1 = 4'd4;
	localparam logic [3:0] S_REL  = 4'd5;
	localparam logic [3:0] S_CLS  = 4'd6;
	localparam logic [3:0] S_DIV2 = 4'd7;
	localparam logic [3:0] S_TTC  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	logic [wttc_pkg::CFG_LEN_W-1:0]  window_length_q;
	logic [wttc_pkg::CFG_DATA_W-1:0] min_speed_q;
	logic [wttc_pkg::CFG_DATA_W-1:0] ttc_limit_q;
	logic                            in_lane_q;
	logic signed [wttc_pkg::SPEED_W-1:0] ego_q;

	wttc_pkg::win_req_t win_req;
	logic [CNT_W-1:0]   win_count;
	logic [DIST_W-1:0]  win_new_dist;
	logic [DIST_W-1:0]  win_old_dist;
	logic [TIME_W-1:0]  win_new_time;
	logic [TIME_W-1:0]  win_old_time;

	logic [TIME_W-1:0]              span_d;
	logic                           neg_d;
	logic [DIST_W-1:0]              mag_d;
	logic [TIME_W-1:0]              span_q;
	logic                           neg_q;
	logic [DIST_W-1:0]              mag_q;
	logic [DIST_W-1:0]              dnew_q;
	logic [wttc_pkg::TTC_NUM_W-1:0] num2_q;
	logic [NUM_W-1:0]               prod1;

	logic signed [REL_W-1:0] speed_s;
	logic signed [REL_W-1:0] ego_s;
	logic signed [REL_W-1:0] rel_d;
	logic signed [REL_W-1:0] rel_q;
	logic signed [REL_W-1:0] rel_neg;
	logic signed [REL_W-1:0] min_pos;
	logic signed [REL_W-1:0] min_neg;
	logic                    stationary;

	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;

	logic [TTC_W-1:0] ttc_sat;
	logic             ttc_low;

	logic                          res_load;
	logic [TTC_W-1:0]              res_ttc_d;
	logic [wttc_pkg::STATUS_W-1:0] res_status_d;
	logic                          res_low_d;
	logic [TTC_W-1:0]              res_ttc_q;
	logic [wttc_pkg::STATUS_W-1:0] res_status_q;
	logic                          res_low_q;

	logic                          out_free;
	logic                          out_load;
	logic                          out_valid_q;
	logic [TTC_W-1:0]              out_ttc_q;
	logic [wttc_pkg::STATUS_W-1:0] out_status_q;
	logic                          out_low_q;

	wttc_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (win_req),
		.wr_dist  (events.distance_mm),
		.wr_time  (events.timestamp_us),
		.win_len  (window_length_q),
		.count    (win_count),
		.new_dist (win_new_dist),
		.new_time (win_new_time),
		.old_dist (win_old_dist),
		.old_time (win_old_time)
	);

	wttc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// window arithmetic
	assign span_d = win_new_time - win_old_time;
	assign neg_d  = win_new_dist < win_old_dist;
	assign mag_d  = neg_d ? win_old_dist - win_new_dist : win_new_dist - win_old_dist;
	assign prod1  = NUM_W'(mag_q) * NUM_W'(wttc_pkg::SPEED_SCALE);

	// relative speed, sign-magnitude speed minus ego speed
	assign speed_s = $signed(REL_W'(div_quot));
	assign ego_s   = REL_W'(ego_q);
	assign rel_d   = neg_q ? (-speed_s - ego_s) : (speed_s - ego_s);
	assign rel_neg = -rel_q;

	assign min_pos    = $signed(REL_W'(min_speed_q));
	assign min_neg    = -min_pos;
	assign stationary = (rel_q < min_pos) && (rel_q > min_neg);

	assign div_num = (state_q == S_MUL) ? prod1 : NUM_W'(num2_q);
	assign div_den = (state_q == S_MUL) ? DEN_W'(span_q) : rel_neg[DEN_W-1:0];

	assign ttc_sat = (|div_quot[NUM_W-1:TTC_W]) ? wttc_pkg::TTC_INFINITE : div_quot[TTC_W-1:0];
	assign ttc_low = (ttc_sat != wttc_pkg::TTC_INFINITE) && (ttc_sat < ttc_limit_q);

	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		state_d      = state_q;
		win_req      = '0;
		div_start    = 1'b0;
		res_load     = 1'b0;
		res_ttc_d    = wttc_pkg::TTC_INFINITE;
		res_status_d = wttc_pkg::ST_NOT_IN_LANE;
		res_low_d    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (events.valid) begin
					case (events.command)
						wttc_pkg::CMD_SAMPLE: begin
							win_req.wr = 1'b1;
							if (in_lane_q) begin
								state_d = S_READ;
							end
						end
						wttc_pkg::CMD_LANE: begin
							if (events.in_lane) begin
								state_d = S_READ;
							end else begin
								res_load     = 1'b1;
								res_status_d = wttc_pkg::ST_NOT_IN_LANE;
								state_d      = S_DONE;
							end
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				if (win_count < CNT_W'(wttc_pkg::MIN_SAMPLES)) begin
					res_load     = 1'b1;
					res_status_d = wttc_pkg::ST_INSUFFICIENT;
					state_d      = S_DONE;
				end else begin
					win_req.rd = 1'b1;
					state_d    = S_SPAN;
				end
			end
			S_SPAN: begin
				if (span_d == '0) begin
					res_load     = 1'b1;
					res_status_d = wttc_pkg::ST_INVALID_TIME;
					state_d      = S_DONE;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				div_start = 1'b1;
				state_d   = S_DIV1;
			end
			S_DIV1: begin
				if (div_done) begin
					state_d = S_REL;
				end
			end
			S_REL: begin
				state_d = S_CLS;
			end
			S_CLS: begin
				if (stationary) begin
					res_load     = 1'b1;
					res_status_d = wttc_pkg::ST_STATIONARY;
					state_d      = S_DONE;
				end else if (rel_q < 0) begin
					div_start = 1'b1;
					state_d   = S_DIV2;
				end else begin
					res_load     = 1'b1;
					res_status_d = wttc_pkg::ST_MOVING_AWAY;
					state_d      = S_DONE;
				end
			end
			S_DIV2: begin
				if (div_done) begin
					state_d = S_TTC;
				end
			end
			S_TTC: begin
				res_load     = 1'b1;
				res_ttc_d    = ttc_sat;
				res_status_d = wttc_pkg::ST_APPROACHING;
				res_low_d    = ttc_low;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			window_length_q <= wttc_pkg::RST_WINDOW_LENGTH;
			min_speed_q     <= wttc_pkg::RST_MIN_SPEED;
			ttc_limit_q     <= wttc_pkg::RST_TTC_LIMIT;
			in_lane_q       <= 1'b0;
			ego_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					wttc_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg_data[wttc_pkg::CFG_LEN_W-1:0];
					wttc_pkg::REG_MIN_SPEED:     min_speed_q     <= cfg_data;
					wttc_pkg::REG_TTC_LIMIT:     ttc_limit_q     <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_IDLE && events.valid) begin
				case (events.command)
					wttc_pkg::CMD_LANE: in_lane_q <= events.in_lane;
					wttc_pkg::CMD_EGO:  ego_q     <= events.ego_speed_mm_s;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SPAN) begin
			span_q <= span_d;
			neg_q  <= neg_d;
			mag_q  <= mag_d;
			dnew_q <= win_new_dist;
		end
		if (state_q == S_MUL) begin
			num2_q <= wttc_pkg::TTC_NUM_W'(dnew_q) *
				wttc_pkg::TTC_NUM_W'(wttc_pkg::TTC_SCALE);
		end
		if (state_q == S_REL) begin
			rel_q <= rel_d;
		end
		if (res_load) begin
			res_ttc_q    <= res_ttc_d;
			res_status_q <= res_status_d;
			res_low_q    <= res_low_d;
		end
		if (out_load) begin
			out_ttc_q    <= res_ttc_q;
			out_status_q <= res_status_q;
			out_low_q    <= res_low_q;
		end
	end

	assign events.ready          = (state_q == S_IDLE);
	assign results.valid         = out_valid_q;
	assign results.ttc_ms        = out_ttc_q;
	assign results.motion_status = out_status_q;
	assign results.low_ttc       = out_low_q;

	`WTTC_ASSERT_IMP(a_out_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_DONE)
	`WTTC_ASSERT_IMP(a_div_in_div_state, clk, arst_n, div_done, state_q == S_DIV1 || state_q == S_DIV2)
	`WTTC_ASSERT_IMP(a_low_ttc_approach, clk, arst_n, out_valid_q && out_low_q, out_status_q == wttc_pkg::ST_APPROACHING && out_ttc_q != wttc_pkg::TTC_INFINITE)
	`WTTC_ASSERT_NXT(a_load_shows, clk, arst_n, out_load, out_valid_q && state_q == S_IDLE)

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed time-to-collision testbench
// The first part is a short table of events and register writes. Where the
// outcome is plain from the row, the row gives the expected status. Random
// phases follow, mostly target tracks with some noise, and each phase runs
// under its own register settings. The other transactions are scored against a
// window and speed predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import wttc_pkg::*;

	localparam int DEPTH          = WINDOW_DEPTH_DEF;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLDOFF_CYCLES = 500;
	localparam int HOLDOFF_AFTER  = 150;
	localparam int PHASE_ITEMS    = 100;

	localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [STATUS_W-1:0]  ANY_STATUS = '0;
	localparam logic [15:0]          STALL_PATTERN = 16'b1011_0010_1110_0101;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic [DIST_W-1:0]         distance;
		logic [TIME_W-1:0]         stamp;
		logic                      in_lane;
		logic signed [SPEED_W-1:0] ego;
	} evt_t;

	typedef struct packed {
		logic [TTC_W-1:0]    ttc;
		logic [STATUS_W-1:0] status;
		logic                low;
	} res_t;

	typedef enum logic {ROW_EVT, ROW_CFG} row_kind_e;

	// ROW_CFG rows: code is the register index, dist_mm the value written
	typedef struct packed {
		row_kind_e           kind;
		logic [1:0]          code;
		logic [15:0]         dist_mm;
		logic [31:0]         stamp;
		logic                lane;
		logic [15:0]         ego;
		logic                typed;
		logic [STATUS_W-1:0] x_status;
	} row_t;

	localparam row_t DIRECTED_ROWS [0:32] = '{
		'{ROW_EVT, CMD_LANE,   16'd0,     32'd0,         1'b0, 16'h0000, 1'b1, ST_NOT_IN_LANE},
		'{ROW_EVT, CMD_SAMPLE, 16'd0,     32'd0,         1'b1, 16'hFFFF, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_LANE,   16'd0,     32'd0,         1'b1, 16'h0000, 1'b1, ST_INSUFFICIENT},
		'{ROW_EVT, CMD_SAMPLE, 16'd65535, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b1, ST_INSUFFICIENT},
		'{ROW_EVT, CMD_SAMPLE, 16'd1000,  32'd0,         1'b0, 16'h0000, 1'b1, ST_INVALID_TIME},
		'{ROW_EVT, CMD_UNUSED, 16'hFFFF,  32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_EGO,    16'd0,     32'd0,         1'b0, 16'h7FFF, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd2000,  32'd1000000,   1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_EGO,    16'd0,     32'd0,         1'b0, 16'h8000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_LANE,   16'd0,     32'd0,         1'b1, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_EGO,    16'd0,     32'd0,         1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_CFG, REG_WINDOW_LENGTH, 16'd3, 32'd0,      1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_CFG, REG_MIN_SPEED,     16'd0, 32'd0,      1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_CFG, REG_UNUSED,    16'hFFFF, 32'd0,       1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_CFG, REG_TTC_LIMIT, 16'hFFFF, 32'd0,       1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd10000, 32'd2000000,   1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd65535, 32'd3000000,   1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd65535, 32'd4000000,   1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd65534, 32'd5000000,   1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_EGO,    16'd0,     32'd0,         1'b0, 16'h0001, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_LANE,   16'd0,     32'd0,         1'b1, 16'h0000, 1'b1, ST_APPROACHING},
		'{ROW_CFG, REG_MIN_SPEED, 16'hFFFF, 32'd0,       1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_CFG, REG_TTC_LIMIT, 16'd0,    32'd0,       1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_LANE,   16'd0,     32'd0,         1'b1, 16'h0000, 1'b1, ST_STATIONARY},
		'{ROW_CFG, REG_MIN_SPEED, 16'd300,  32'd0,       1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd0,     32'd5000000,   1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_CFG, REG_TTC_LIMIT, 16'd2000, 32'd0,       1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd500,   32'd5500000,   1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_CFG, REG_WINDOW_LENGTH, 16'd0, 32'd0,      1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd400,   32'd6000000,   1'b0, 16'h0000, 1'b1, ST_INSUFFICIENT},
		'{ROW_CFG, REG_WINDOW_LENGTH, 16'd31, 32'd0,     1'b0, 16'h0000, 1'b0, ANY_STATUS},
		'{ROW_EVT, CMD_SAMPLE, 16'd350,   32'd6250000,   1'b0, 16'h0000, 1'b1, ST_INSUFFICIENT},
		'{ROW_EVT, CMD_SAMPLE, 16'd300,   32'd6500000,   1'b0, 16'h0000, 1'b0, ANY_STATUS}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wttc_evt_if ev ();
	wttc_res_if res ();

	windowed_time_to_collision u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (ev),
		.results   (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// tracker state and register copies
	logic [DIST_W-1:0]         trk_dist [DEPTH];
	logic [TIME_W-1:0]         trk_stamp [DEPTH];
	int                        trk_count;
	int                        trk_head;
	logic                      trk_in_lane;
	logic signed [SPEED_W-1:0] trk_ego;
	logic [CFG_LEN_W-1:0]      cfg_window;
	logic [CFG_DATA_W-1:0]     cfg_min_speed;
	logic [CFG_DATA_W-1:0]     cfg_ttc_limit;

	res_t ttc_expected [$];
	int   fail_count;
	int   results_seen;
	bit   sender_at_neg;
	bit   gaps_on;
	int   burst_left;
	int   path_dist;
	logic [TIME_W-1:0] path_time;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic res_t judge_window();
		res_t r;
		int newest, oldest;
		logic [TIME_W-1:0] span;
		logic [DIST_W-1:0] dnew, dold;
		longint unsigned mag, speed_mag, rel_mag, ttc;
		longint speed, rel;
		r = '{TTC_INFINITE, ST_INSUFFICIENT, 1'b0};
		if (trk_count < 3)
			return r;
		newest = (trk_head + DEPTH - 1) % DEPTH;
		oldest = (trk_head + DEPTH - trk_count) % DEPTH;
		span = trk_stamp[newest] - trk_stamp[oldest];
		if (span == '0) begin
			r.status = ST_INVALID_TIME;
			return r;
		end
		dnew = trk_dist[newest];
		dold = trk_dist[oldest];
		mag = (dnew >= dold) ? longint'(dnew - dold) : longint'(dold - dnew);
		speed_mag = (mag * 64'd1000000) / {32'd0, span};
		speed = (dnew >= dold) ? longint'(speed_mag) : -longint'(speed_mag);
		rel = speed - longint'(trk_ego);
		rel_mag = (rel < 0) ? longint'(-rel) : longint'(rel);
		if (rel_mag < {48'd0, cfg_min_speed}) begin
			r.status = ST_STATIONARY;
		end else if (rel < 0) begin
			ttc = ({48'd0, dnew} * 64'd1000) / rel_mag;
			if (ttc > 64'd65535)
				ttc = 64'd65535;
			r.ttc = ttc[15:0];
			r.status = ST_APPROACHING;
			r.low = (r.ttc != TTC_INFINITE) && (r.ttc < cfg_ttc_limit);
		end else begin
			r.status = ST_MOVING_AWAY;
		end
		return r;
	endfunction

	// updates the tracker; returns 1 when the event yields a result
	function automatic bit predict_ttc(input evt_t e, output res_t r);
		int len;
		r = '{TTC_INFINITE, ST_NOT_IN_LANE, 1'b0};
		case (e.command)
			CMD_SAMPLE: begin
				trk_dist[trk_head] = e.distance;
				trk_stamp[trk_head] = e.stamp;
				trk_head = (trk_head + 1) % DEPTH;
				len = (cfg_window == '0) ? 1 : (int'(cfg_window) > DEPTH ? DEPTH : int'(cfg_window));
				trk_count = (trk_count + 1 > len) ? len : trk_count + 1;
				if (!trk_in_lane)
					return 1'b0;
				r = judge_window();
				return 1'b1;
			end
			CMD_LANE: begin
				trk_in_lane = e.in_lane;
				if (trk_in_lane)
					r = judge_window();
				return 1'b1;
			end
			CMD_EGO: begin
				trk_ego = e.ego;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic evt_t make_event();
		evt_t e;
		int pick, step;
		e.command = CMD_SAMPLE;
		e.distance = DIST_W'($urandom);
		e.stamp = $urandom;
		e.in_lane = 1'($urandom);
		e.ego = SPEED_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 68) begin
			step = $urandom_range(0, 300);
			if ($urandom_range(0, 19) == 0 || path_dist < 500)
				path_dist = $urandom_range(3000, 65535);
			else if ($urandom_range(0, 5) == 0)
				path_dist = (path_dist + step > 65535) ? 65535 : path_dist + step;
			else if ($urandom_range(0, 4) != 0)
				path_dist = path_dist - step;
			case ($urandom_range(0, 29))
				0:       ;
				1:       path_time = $urandom;
				default: path_time = path_time + $urandom_range(1000, 250000);
			endcase
			e.distance = DIST_W'(path_dist);
			e.stamp = path_time;
		end else if (pick < 80) begin
			e.command = CMD_LANE;
			e.in_lane = ($urandom_range(0, 7) != 0);
		end else if (pick < 88) begin
			e.command = CMD_EGO;
			if ($urandom_range(0, 2) != 0)
				e.ego = SPEED_W'(int'($urandom_range(0, 6000)) - 3000);
		end else if (pick < 92) begin
			e.command = CMD_UNUSED;
		end
		return e;
	endfunction

	task automatic offer_event(input evt_t e, input bit typed, input res_t typed_res);
		int gap;
		res_t r;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on)
				gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 90 : 12);
		end
		burst_left--;
		if (!sender_at_neg)
			@(negedge clk);
		if (gap > 0) begin
			ev.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ev.valid <= 1'b1;
		ev.command <= e.command;
		ev.distance_mm <= e.distance;
		ev.timestamp_us <= e.stamp;
		ev.in_lane <= e.in_lane;
		ev.ego_speed_mm_s <= e.ego;
		@(posedge clk);
		while (!ev.ready)
			@(posedge clk);
		if (predict_ttc(e, r))
			ttc_expected.insert(ttc_expected.size(), typed ? typed_res : r);
		@(negedge clk);
		sender_at_neg = 1'b1;
	endtask

	// drop valid, wait for every result, then let the block go idle
	task automatic settle_block();
		if (!sender_at_neg)
			@(negedge clk);
		ev.valid <= 1'b0;
		while (ttc_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		sender_at_neg = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle_block();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sender_at_neg = 1'b1;
		case (idx)
			REG_WINDOW_LENGTH: cfg_window = val[CFG_LEN_W-1:0];
			REG_MIN_SPEED:     cfg_min_speed = val;
			REG_TTC_LIMIT:     cfg_ttc_limit = val;
			default:           ;
		endcase
	endtask

	// receiver: stall modes, plus one long hold-off while the sender is busy
	initial begin : result_drain
		int holdoff_left;
		int stall_cycle;
		int stall_mode;
		bit holdoff_done;
		holdoff_left = 0;
		stall_cycle = 0;
		stall_mode = 0;
		holdoff_done = 1'b0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall_cycle++;
			if (stall_cycle % 97 == 0)
				stall_mode = $urandom_range(0, 3);
			if (holdoff_left > 0) begin
				holdoff_left--;
				res.ready <= 1'b0;
			end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER && ev.valid) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
				res.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0:       res.ready <= 1'b1;
					1:       res.ready <= STALL_PATTERN[stall_cycle % 16];
					2:       res.ready <= ($urandom_range(0, 3) != 0);
					default: res.ready <= 1'($urandom);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (ttc_expected.size() == 0) begin
				$error("unexpected result: ttc_ms %0d, motion_status %0d, low_ttc %0d",
					res.ttc_ms, res.motion_status, res.low_ttc);
				fail_count++;
			end else begin
				want = ttc_expected[0];
				ttc_expected.delete(0);
				if (res.ttc_ms !== want.ttc) begin
					$error("ttc_ms: expected %0d, actual %0d", want.ttc, res.ttc_ms);
					fail_count++;
				end
				if (res.motion_status !== want.status) begin
					$error("motion_status: expected %0d, actual %0d", want.status,
						res.motion_status);
					fail_count++;
				end
				if (res.low_ttc !== want.low) begin
					$error("low_ttc: expected %0d, actual %0d", want.low, res.low_ttc);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if (arst_n) begin
			if ((ev.valid && ev.ready) || (res.valid && res.ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		row_t row;
		evt_t e;
		int done_items;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ev.valid = 1'b0;
		ev.command = CMD_SAMPLE;
		ev.distance_mm = '0;
		ev.timestamp_us = '0;
		ev.in_lane = 1'b0;
		ev.ego_speed_mm_s = '0;
		fail_count = 0;
		results_seen = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		path_dist = 20000;
		path_time = 32'd10000000;
		trk_count = 0;
		trk_head = 0;
		trk_in_lane = 1'b0;
		trk_ego = '0;
		cfg_window = 5'd10;
		cfg_min_speed = 16'd300;
		cfg_ttc_limit = 16'd2000;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		sender_at_neg = 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_CFG) begin
				write_reg(row.code, row.dist_mm);
			end else begin
				e = '{row.code, row.dist_mm, row.stamp, row.lane, row.ego};
				offer_event(e, row.typed, '{TTC_INFINITE, row.x_status, 1'b0});
			end
		end

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_WINDOW_LENGTH, 16'd16);
					write_reg(REG_MIN_SPEED, 16'd300);
					write_reg(REG_TTC_LIMIT, 16'd2000);
				end
				1: begin
					write_reg(REG_WINDOW_LENGTH, 16'd3);
					write_reg(REG_MIN_SPEED, 16'd0);
					write_reg(REG_TTC_LIMIT, 16'hFFFF);
				end
				2: begin
					write_reg(REG_WINDOW_LENGTH, 16'd31);
					write_reg(REG_MIN_SPEED, 16'($urandom_range(0, 1000)));
					write_reg(REG_TTC_LIMIT, 16'($urandom_range(0, 5000)));
					write_reg(REG_UNUSED, 16'($urandom));
				end
				3: begin
					write_reg(REG_WINDOW_LENGTH, 16'($urandom_range(3, 15)));
					write_reg(REG_MIN_SPEED, 16'hFFFF);
					write_reg(REG_TTC_LIMIT, 16'd0);
				end
				default: begin
					write_reg(REG_WINDOW_LENGTH, 16'($urandom_range(0, 31)));
					write_reg(REG_MIN_SPEED, 16'($urandom_range(0, 3000)));
					write_reg(REG_TTC_LIMIT, 16'($urandom));
				end
			endcase
			// one phase runs back to back with no sender gaps
			gaps_on = (phase != 2);
			done_items = 0;
			while (done_items < PHASE_ITEMS) begin
				e = make_event();
				if (e.command != CMD_UNUSED)
					done_items++;
				offer_event(e, 1'b0, '0);
			end
		end

		settle_block();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
